### rtl/sve_pkg.sv
// Shared types and constants of the shadow volume extruder.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package sve_pkg;

	localparam int MAX_VERTS = 4096;
	localparam int IDX_W     = 12;
	localparam int SLOT_W    = 13;
	localparam int COORD_W   = 32;
	localparam int NORM_W    = 16;
	localparam int PROD_W    = COORD_W + NORM_W;
	localparam int DOT_W     = PROD_W + 2;
	localparam int NSTEPS    = 8;
	localparam int STEP_W    = 3;
	localparam int EDGE_W    = 3;
	localparam int REG_IDX_W = 3;
	localparam int DATA_W    = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [SLOT_W-1:0]         slot_t;
	typedef logic [STEP_W-1:0]         step_t;

	typedef enum logic {
		MODE_VERTEX = 1'b0,
		MODE_TRI    = 1'b1
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FAR_X  = 3'd0,
		REG_FAR_Y  = 3'd1,
		REG_FAR_Z  = 3'd2,
		REG_NEAR_X = 3'd3,
		REG_NEAR_Y = 3'd4,
		REG_NEAR_Z = 3'd5,
		REG_VCOUNT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		coord_t far_x;
		coord_t far_y;
		coord_t far_z;
		coord_t near_x;
		coord_t near_y;
		coord_t near_z;
		slot_t  vcount;
	} sve_cfg_t;

	// a0/a1 carry the near and far slot of a vertex transaction
	typedef struct packed {
		mode_t             mode;
		logic              neg;
		logic [EDGE_W-1:0] open_mask;
		slot_t             a0;
		slot_t             b0;
		slot_t             c0;
		slot_t             a1;
		slot_t             b1;
		slot_t             c1;
		coord_t            near_x;
		coord_t            near_y;
		coord_t            near_z;
		coord_t            far_x;
		coord_t            far_y;
		coord_t            far_z;
	} sve_item_t;

endpackage

`default_nettype wire

### rtl/sve_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on sve_pkg.
`default_nettype none

interface sve_in_if
	import sve_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              mode;
	idx_t              vert_index;
	coord_t            pos_x;
	coord_t            pos_y;
	coord_t            pos_z;
	idx_t              idx_a;
	idx_t              idx_b;
	idx_t              idx_c;
	norm_t             norm_x;
	norm_t             norm_y;
	norm_t             norm_z;
	logic [EDGE_W-1:0] open_mask;

	modport source (
		output valid, mode, vert_index, pos_x, pos_y, pos_z,
		idx_a, idx_b, idx_c, norm_x, norm_y, norm_z, open_mask,
		input  ready
	);
	modport sink (
		input  valid, mode, vert_index, pos_x, pos_y, pos_z,
		idx_a, idx_b, idx_c, norm_x, norm_y, norm_z, open_mask,
		output ready
	);
endinterface

interface sve_out_if
	import sve_pkg::*;
();
	logic   valid;
	logic   ready;
	logic   kind;
	slot_t  slot;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	slot_t  tri_first;
	slot_t  tri_second;
	slot_t  tri_third;
	logic   last;

	modport source (
		output valid, kind, slot, out_x, out_y, out_z,
		tri_first, tri_second, tri_third, last,
		input  ready
	);
	modport sink (
		input  valid, kind, slot, out_x, out_y, out_z,
		tri_first, tri_second, tri_third, last,
		output ready
	);
endinterface

`default_nettype wire

### rtl/shadow_volume_extruder.sv
// Top level of the shadow volume extruder: config registers, front pipeline, result sequencer.
// Depends on sve_pkg, sve_if, sve_cfg_regs, sve_front and sve_emit.
//
//  port      | dir | transaction
//  ----------+-----+------------------------------------------------
//  item      | in  | vertex or triangle, valid/ready
//  result    | out | near/far vertex or cap/side triangle, valid/ready
//  wr_*      | in  | register write, one per cycle with wr_en
//
// A vertex gives 2 results, a triangle 2 plus 2 per open edge (up to 8), one at a time
// through the single result register. The first result passes the input, product,
// facing-sign and result registers. Reset clears config, step and all valid flags. A stalled
// result holds the sequencer; three front stages keep taking items until they fill.
`default_nettype none

module shadow_volume_extruder
	import sve_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [DATA_W-1:0]    wr_data,
	sve_in_if.sink                    item,
	sve_out_if.source                 result
);

	sve_cfg_t  cfg;
	sve_item_t work;
	logic      work_valid;
	logic      work_ready;

	sve_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	sve_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.work       (work),
		.work_valid (work_valid),
		.work_ready (work_ready)
	);

	sve_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (work),
		.work_valid (work_valid),
		.work_ready (work_ready),
		.result     (result)
	);

endmodule

`default_nettype wire

### rtl/sve_cfg_regs.sv
// Configuration register file: offsets and vertex count.
// Depends on sve_pkg.
`default_nettype none

module sve_cfg_regs
	import sve_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [DATA_W-1:0]    wr_data,
	output sve_cfg_t                  cfg
);

	sve_cfg_t cfg_q;
	slot_t    vcount_sat;

	assign vcount_sat = (wr_data[SLOT_W-1:0] > SLOT_W'(MAX_VERTS)) ?
		SLOT_W'(MAX_VERTS) : wr_data[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_FAR_X:  cfg_q.far_x  <= coord_t'(wr_data);
				REG_FAR_Y:  cfg_q.far_y  <= coord_t'(wr_data);
				REG_FAR_Z:  cfg_q.far_z  <= coord_t'(wr_data);
				REG_NEAR_X: cfg_q.near_x <= coord_t'(wr_data);
				REG_NEAR_Y: cfg_q.near_y <= coord_t'(wr_data);
				REG_NEAR_Z: cfg_q.near_z <= coord_t'(wr_data);
				REG_VCOUNT: cfg_q.vcount <= vcount_sat;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/sve_front.sv
// Front pipeline: input register, offset sums and normal products, facing sign.
// Depends on sve_pkg and sve_in_if.
`default_nettype none

module sve_front
	import sve_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire sve_cfg_t cfg,
	sve_in_if.sink        item,
	output sve_item_t     work,
	output logic          work_valid,
	input  wire logic     work_ready
);

	// stage 1: captured transaction
	logic              valid_s1;
	mode_t             mode_s1;
	idx_t              vert_index_s1;
	coord_t            pos_x_s1, pos_y_s1, pos_z_s1;
	idx_t              idx_a_s1, idx_b_s1, idx_c_s1;
	norm_t             norm_x_s1, norm_y_s1, norm_z_s1;
	logic [EDGE_W-1:0] open_mask_s1;

	// stage 2: products and sums
	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2, prod_z_s2;
	sve_item_t                item_s2;

	// stage 3: facing sign resolved
	logic      valid_s3;
	sve_item_t item_s3;

	logic                     load_s3, load_s2, load_s1;
	logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
	logic signed [DOT_W-1:0]  dot;
	idx_t                     ia, ib, ic;
	sve_item_t                next_s2;
	sve_item_t                next_s3;

	assign load_s3 = !valid_s3 || work_ready;
	assign load_s2 = !valid_s2 || load_s3;
	assign load_s1 = !valid_s1 || load_s2;
	assign item.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item.valid) begin
			mode_s1       <= mode_t'(item.mode);
			vert_index_s1 <= item.vert_index;
			pos_x_s1      <= item.pos_x;
			pos_y_s1      <= item.pos_y;
			pos_z_s1      <= item.pos_z;
			idx_a_s1      <= item.idx_a;
			idx_b_s1      <= item.idx_b;
			idx_c_s1      <= item.idx_c;
			norm_x_s1     <= item.norm_x;
			norm_y_s1     <= item.norm_y;
			norm_z_s1     <= item.norm_z;
			open_mask_s1  <= item.open_mask;
		end
	end

	assign prod_x = cfg.far_x * norm_x_s1;
	assign prod_y = cfg.far_y * norm_y_s1;
	assign prod_z = cfg.far_z * norm_z_s1;

	assign ia = (mode_s1 == MODE_TRI) ? idx_a_s1 : vert_index_s1;
	assign ib = idx_b_s1;
	assign ic = idx_c_s1;

	always_comb begin
		next_s2            = '0;
		next_s2.mode       = mode_s1;
		next_s2.open_mask  = open_mask_s1;
		next_s2.a0         = {1'b0, ia};
		next_s2.b0         = {1'b0, ib};
		next_s2.c0         = {1'b0, ic};
		next_s2.a1         = cfg.vcount + {1'b0, ia};
		next_s2.b1         = cfg.vcount + {1'b0, ib};
		next_s2.c1         = cfg.vcount + {1'b0, ic};
		next_s2.near_x     = pos_x_s1 + cfg.near_x;
		next_s2.near_y     = pos_y_s1 + cfg.near_y;
		next_s2.near_z     = pos_z_s1 + cfg.near_z;
		next_s2.far_x      = pos_x_s1 + cfg.far_x;
		next_s2.far_y      = pos_y_s1 + cfg.far_y;
		next_s2.far_z      = pos_z_s1 + cfg.far_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			prod_x_s2 <= prod_x;
			prod_y_s2 <= prod_y;
			prod_z_s2 <= prod_z;
			item_s2   <= next_s2;
		end
	end

	assign dot = {{2{prod_x_s2[PROD_W-1]}}, prod_x_s2}
		+ {{2{prod_y_s2[PROD_W-1]}}, prod_y_s2}
		+ {{2{prod_z_s2[PROD_W-1]}}, prod_z_s2};

	always_comb begin
		next_s3     = item_s2;
		next_s3.neg = dot[DOT_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && valid_s2) begin
			item_s3 <= next_s3;
		end
	end

	assign work       = item_s3;
	assign work_valid = valid_s3;

endmodule

`default_nettype wire

### rtl/sve_emit.sv
// Result sequencer: steps through the results of one transaction into the output register.
// Depends on sve_pkg and sve_out_if.
`default_nettype none

module sve_emit
	import sve_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sve_item_t work,
	input  wire logic      work_valid,
	output logic           work_ready,
	sve_out_if.source      result
);

	localparam logic [NSTEPS-1:0] VERT_STEPS = NSTEPS'(2'b11);

	step_t             step_q;
	logic              valid_q;
	logic              kind_q;
	slot_t             slot_q;
	coord_t            x_q, y_q, z_q;
	slot_t             first_q, second_q, third_q;
	logic              last_q;

	logic              load;
	logic [NSTEPS-1:0] steps;
	step_t             nxt;
	logic              more;
	slot_t             u0, v0, u1, v1;
	slot_t             p, q, r;

	assign steps = (work.mode == MODE_TRI) ?
		{{2{work.open_mask[2]}}, {2{work.open_mask[1]}}, {2{work.open_mask[0]}}, 2'b11} :
		VERT_STEPS;

	always_comb begin
		nxt  = '0;
		more = 1'b0;
		for (int j = NSTEPS - 1; j >= 0; j--) begin
			if (steps[j] && (j > int'(step_q))) begin
				nxt  = STEP_W'(j);
				more = 1'b1;
			end
		end
	end

	always_comb begin
		case (step_q[2:1])
			2'd2: begin
				u0 = work.b0; v0 = work.c0; u1 = work.b1; v1 = work.c1;
			end
			2'd3: begin
				u0 = work.c0; v0 = work.a0; u1 = work.c1; v1 = work.a1;
			end
			default: begin
				u0 = work.a0; v0 = work.b0; u1 = work.a1; v1 = work.b1;
			end
		endcase
	end

	always_comb begin
		if (step_q == '0) begin
			p = work.c0; q = work.b0; r = work.a0;
		end else if (step_q == step_t'(1)) begin
			p = work.a1; q = work.b1; r = work.c1;
		end else if (!step_q[0]) begin
			p = u0; q = v0; r = v1;
		end else begin
			p = v1; q = u1; r = u0;
		end
	end

	assign load       = work_valid && (!valid_q || result.ready);
	assign work_ready = load && !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= more ? nxt : '0;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= work.mode;
			last_q <= !more;
			if (work.mode == MODE_TRI) begin
				slot_q   <= '0;
				x_q      <= '0;
				y_q      <= '0;
				z_q      <= '0;
				first_q  <= work.neg ? r : p;
				second_q <= q;
				third_q  <= work.neg ? p : r;
			end else begin
				slot_q   <= step_q[0] ? work.a1 : work.a0;
				x_q      <= step_q[0] ? work.far_x : work.near_x;
				y_q      <= step_q[0] ? work.far_y : work.near_y;
				z_q      <= step_q[0] ? work.far_z : work.near_z;
				first_q  <= '0;
				second_q <= '0;
				third_q  <= '0;
			end
		end
	end

	assign result.valid      = valid_q;
	assign result.kind       = kind_q;
	assign result.slot       = slot_q;
	assign result.out_x      = x_q;
	assign result.out_y      = y_q;
	assign result.out_z      = z_q;
	assign result.tri_first  = first_q;
	assign result.tri_second = second_q;
	assign result.tri_third  = third_q;
	assign result.last       = last_q;

endmodule

`default_nettype wire

### dv/shadow_volume_extruder_tb.sv
// Self-checking testbench for shadow_volume_extruder: vertex and triangle transactions
// are checked against an in-bench model of the near/far copies and volume triangles.
// Depends on sve_pkg, sve_if and the shadow_volume_extruder RTL.
`timescale 1ns / 1ps

module shadow_volume_extruder_tb;
	import sve_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int MAX_GAP        = 18;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_ITEMS    = 20;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		mode_t             mode;
		idx_t              vert_index;
		coord_t            pos_x;
		coord_t            pos_y;
		coord_t            pos_z;
		idx_t              idx_a;
		idx_t              idx_b;
		idx_t              idx_c;
		norm_t             norm_x;
		norm_t             norm_y;
		norm_t             norm_z;
		logic [EDGE_W-1:0] open_mask;
	} mesh_item_t;

	typedef struct packed {
		mode_t  kind;
		slot_t  slot;
		coord_t x;
		coord_t y;
		coord_t z;
		slot_t  t0;
		slot_t  t1;
		slot_t  t2;
		logic   last;
	} volume_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [DATA_W-1:0]    wr_data;

	sve_in_if  item_ch ();
	sve_out_if result_ch ();

	shadow_volume_extruder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	sve_cfg_t       shadow_cfg;
	mesh_item_t     pending_items [$];
	mesh_item_t     offered;
	volume_result_t expected_volume [$];
	int             error_count = 0;
	int             send_gap;
	int             recv_gap;
	int             stall_cycles = 0;
	int             holds_requested = 0;
	int             holds_granted = 0;
	bit             send_no_idle = 0;
	bit             recv_no_idle = 0;

	always #1 clk = ~clk;

	function automatic void extrude_item(input mesh_item_t it);
		slot_t          near_c [0:2];
		slot_t          far_c [0:2];
		slot_t          tp [0:7];
		slot_t          tq [0:7];
		slot_t          tr [0:7];
		int             n;
		int             v;
		bit             neg;
		longint         dot;
		volume_result_t r;
		r = '0;
		if (it.mode == MODE_VERTEX) begin
			r.kind = MODE_VERTEX;
			r.slot = slot_t'(it.vert_index);
			r.x = it.pos_x + shadow_cfg.near_x;
			r.y = it.pos_y + shadow_cfg.near_y;
			r.z = it.pos_z + shadow_cfg.near_z;
			expected_volume.push_back(r);
			r.slot = shadow_cfg.vcount + slot_t'(it.vert_index);
			r.x = it.pos_x + shadow_cfg.far_x;
			r.y = it.pos_y + shadow_cfg.far_y;
			r.z = it.pos_z + shadow_cfg.far_z;
			r.last = 1'b1;
			expected_volume.push_back(r);
		end else begin
			near_c[0] = slot_t'(it.idx_a);
			near_c[1] = slot_t'(it.idx_b);
			near_c[2] = slot_t'(it.idx_c);
			for (int i = 0; i < 3; i++)
				far_c[i] = shadow_cfg.vcount + near_c[i];
			dot = longint'($signed(shadow_cfg.far_x)) * longint'($signed(it.norm_x))
			    + longint'($signed(shadow_cfg.far_y)) * longint'($signed(it.norm_y))
			    + longint'($signed(shadow_cfg.far_z)) * longint'($signed(it.norm_z));
			neg = dot < 0;
			// facing-away winding; the facing-toward case is each triangle reversed
			tp[0] = near_c[2]; tq[0] = near_c[1]; tr[0] = near_c[0];
			tp[1] = far_c[0];  tq[1] = far_c[1];  tr[1] = far_c[2];
			n = 2;
			for (int e = 0; e < 3; e++) begin
				if (it.open_mask[e]) begin
					v = (e + 1) % 3;
					tp[n] = near_c[e];   tq[n] = near_c[v];   tr[n] = far_c[v];
					tp[n+1] = far_c[v];  tq[n+1] = far_c[e];  tr[n+1] = near_c[e];
					n += 2;
				end
			end
			r.kind = MODE_TRI;
			for (int i = 0; i < n; i++) begin
				r.t0 = neg ? tr[i] : tp[i];
				r.t1 = tq[i];
				r.t2 = neg ? tp[i] : tr[i];
				r.last = (i == n - 1);
				expected_volume.push_back(r);
			end
		end
	endfunction

	function automatic string show_result(input volume_result_t r);
		return $sformatf("kind=%0d slot=%0d xyz=%h/%h/%h tri=%0d/%0d/%0d last=%0b",
			r.kind, r.slot, r.x, r.y, r.z, r.t0, r.t1, r.t2, r.last);
	endfunction

	function automatic coord_t random_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	// mostly well-formed: indices below the vertex count, sometimes anywhere
	function automatic mesh_item_t random_item();
		mesh_item_t it;
		int         span;
		span = (shadow_cfg.vcount == 0 || $urandom_range(0, 4) == 0) ?
			MAX_VERTS : int'(shadow_cfg.vcount);
		it.mode       = ($urandom_range(0, 9) < 4) ? MODE_VERTEX : MODE_TRI;
		it.vert_index = idx_t'($urandom_range(0, span - 1));
		it.pos_x      = random_coord();
		it.pos_y      = random_coord();
		it.pos_z      = random_coord();
		it.idx_a      = idx_t'($urandom_range(0, span - 1));
		it.idx_b      = idx_t'($urandom_range(0, span - 1));
		it.idx_c      = idx_t'($urandom_range(0, span - 1));
		it.norm_x     = norm_t'($urandom);
		it.norm_y     = norm_t'($urandom);
		it.norm_z     = norm_t'($urandom);
		it.open_mask  = EDGE_W'($urandom);
		return it;
	endfunction

	task automatic queue_vertex(input idx_t vi, input coord_t x, input coord_t y,
			input coord_t z);
		mesh_item_t it;
		it = random_item();
		it.mode = MODE_VERTEX;
		it.vert_index = vi;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		pending_items.push_back(it);
	endtask

	task automatic queue_triangle(input idx_t a, input idx_t b, input idx_t c,
			input norm_t nx, input norm_t ny, input norm_t nz,
			input logic [EDGE_W-1:0] oe);
		mesh_item_t it;
		it = random_item();
		it.mode = MODE_TRI;
		it.idx_a = a;
		it.idx_b = b;
		it.idx_c = c;
		it.norm_x = nx;
		it.norm_y = ny;
		it.norm_z = nz;
		it.open_mask = oe;
		pending_items.push_back(it);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
		slot_t vc;
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= data;
		case (index)
			REG_FAR_X:  shadow_cfg.far_x = data;
			REG_FAR_Y:  shadow_cfg.far_y = data;
			REG_FAR_Z:  shadow_cfg.far_z = data;
			REG_NEAR_X: shadow_cfg.near_x = data;
			REG_NEAR_Y: shadow_cfg.near_y = data;
			REG_NEAR_Z: shadow_cfg.near_z = data;
			REG_VCOUNT: begin
				vc = data[SLOT_W-1:0];
				shadow_cfg.vcount = (vc > MAX_VERTS) ? slot_t'(MAX_VERTS) : vc;
			end
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic program_config(input coord_t fx, input coord_t fy, input coord_t fz,
			input coord_t nx, input coord_t ny, input coord_t nz,
			input logic [DATA_W-1:0] vc);
		write_reg(REG_FAR_X, fx);
		write_reg(REG_FAR_Y, fy);
		write_reg(REG_FAR_Z, fz);
		write_reg(REG_NEAR_X, nx);
		write_reg(REG_NEAR_Y, ny);
		write_reg(REG_NEAR_Z, nz);
		write_reg(REG_VCOUNT, vc);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_ch.valid || expected_volume.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_gap <= 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (item_ch.valid) begin
				extrude_item(offered);
			end
			if (send_gap != 0) begin
				item_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_items.size() != 0) begin
				offered = pending_items.pop_front();
				item_ch.valid      <= 1'b1;
				item_ch.mode       <= offered.mode;
				item_ch.vert_index <= offered.vert_index;
				item_ch.pos_x      <= offered.pos_x;
				item_ch.pos_y      <= offered.pos_y;
				item_ch.pos_z      <= offered.pos_z;
				item_ch.idx_a      <= offered.idx_a;
				item_ch.idx_b      <= offered.idx_b;
				item_ch.idx_c      <= offered.idx_c;
				item_ch.norm_x     <= offered.norm_x;
				item_ch.norm_y     <= offered.norm_y;
				item_ch.norm_z     <= offered.norm_z;
				item_ch.open_mask  <= offered.open_mask;
				send_gap <= send_no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		int             gap_now;
		volume_result_t seen;
		volume_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			gap_now = recv_gap;
			if (result_ch.valid && result_ch.ready) begin
				seen.kind = mode_t'(result_ch.kind);
				seen.slot = result_ch.slot;
				seen.x    = result_ch.out_x;
				seen.y    = result_ch.out_y;
				seen.z    = result_ch.out_z;
				seen.t0   = result_ch.tri_first;
				seen.t1   = result_ch.tri_second;
				seen.t2   = result_ch.tri_third;
				seen.last = result_ch.last;
				if (expected_volume.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result: %s", show_result(seen));
				end else begin
					want = expected_volume.pop_front();
					if (seen !== want) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("mismatch: expected %s, got %s",
								show_result(want), show_result(seen));
					end
				end
				gap_now = recv_no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (holds_granted < holds_requested) begin
				gap_now = HOLD_CYCLES;
				holds_granted++;
			end
			if (gap_now != 0) begin
				result_ch.ready <= 1'b0;
				recv_gap <= gap_now - 1;
			end else begin
				result_ch.ready <= 1'b1;
				recv_gap <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [DATA_W-1:0] vc_raw;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_VERTEX;
		item_ch.vert_index = '0;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.pos_z = '0;
		item_ch.idx_a = '0;
		item_ch.idx_b = '0;
		item_ch.idx_c = '0;
		item_ch.norm_x = '0;
		item_ch.norm_y = '0;
		item_ch.norm_z = '0;
		item_ch.open_mask = '0;
		result_ch.ready = 1'b0;
		shadow_cfg = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// moderate offsets, small mesh, indices past the vertex count
		program_config(32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
			32'h0000_1999, 32'hFFFF_E667, 32'h0000_0666, 32'd8);
		queue_vertex(0, 32'h0, 32'h0, 32'h0);
		queue_vertex(12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_vertex(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_vertex(2, random_coord(), random_coord(), random_coord());
		for (int oe = 0; oe < 8; oe++)
			queue_triangle(0, 1, 2, (oe % 2) ? -16'sd16384 : 16'sd16384, 16'sd0, 16'sd0,
				EDGE_W'(oe));
		queue_triangle(0, 1, 2, 16'sd16384, 16'sd0, 16'sd0, 3'b111);
		queue_triangle(3, 4, 5, 16'sd0, 16'sd0, 16'sd0, 3'b111);
		queue_triangle(12'hFFF, 12'hFFE, 12'hFFD, -16'sd32768, -16'sd32768, -16'sd32768,
			3'b101);
		queue_triangle(12'hFFF, 12'hFFF, 12'hFFF, 16'sd32767, 16'sd32767, 16'sd32767, 3'b010);
		wait_drained();

		// zero extrusion offset, saturating vertex count, spare register
		program_config(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hDEAD_BEEF);
		queue_triangle(7, 8, 9, 16'sd32767, -16'sd32768, 16'sd1, 3'b111);
		queue_vertex(12'hFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_vertex(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		wait_drained();

		// extreme offsets, empty vertex count
		program_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
			32'h8000_0000, 32'd0);
		queue_triangle(1, 2, 3, 16'sd32767, -16'sd32768, 16'sd32767, 3'b011);
		queue_triangle(1, 2, 3, -16'sd32768, 16'sd32767, -16'sd32768, 3'b110);
		queue_vertex(12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			recv_no_idle = (ph == 1);
			send_no_idle = (ph == 1 || ph == 2);
			case ($urandom_range(0, 3))
				0: vc_raw = DATA_W'($urandom_range(0, MAX_VERTS));
				1: vc_raw = $urandom;
				default: vc_raw = ($urandom & 32'hFFFF_E000) | DATA_W'($urandom_range(3, 64));
			endcase
			program_config(random_coord(), random_coord(), random_coord(),
				random_coord(), random_coord(), random_coord(), vc_raw);
			if (ph == 2)
				holds_requested++;
			repeat (PHASE_ITEMS) pending_items.push_back(random_item());
			wait_drained();
		end

		send_no_idle = 1'b0;
		recv_no_idle = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_volume.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
